// ===== sv/r2y_pkg.sv =====
// Shared types, constants and helper functions of the RGB565 to NV12 converter.
package r2y_pkg;

    // Frame size limits and derived widths
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;
    localparam int CFG_W        = 12;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int LINE_IDX_W   = $clog2(LINE_DEPTH);

    // Field widths
    localparam int PIXEL_W      = 16;
    localparam int LUMA_OFF_W   = 22;
    localparam int CHROMA_OFF_W = 23;
    localparam int PAIR_SUM_W   = 9;
    localparam int LINE_ENTRY_W = 2 * PAIR_SUM_W;

    // Output queue between the two halves
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

    // Colour matrix, fixed point with 15 fractional bits
    localparam logic [31:0] COEF_Y_R   = 32'd80593;
    localparam logic [31:0] COEF_Y_G   = 32'd77855;
    localparam logic [31:0] COEF_Y_B   = 32'd30728;
    localparam logic [31:0] COEF_U_R   = 32'd45483;
    localparam logic [31:0] COEF_U_G   = 32'd43936;
    localparam logic [31:0] COEF_UV_BR = 32'd134771;
    localparam logic [31:0] COEF_V_G   = 32'd55532;
    localparam logic [31:0] COEF_V_B   = 32'd21917;
    localparam logic [31:0] CHROMA_BIAS = 32'd4194304;
    localparam int FRAC_BITS    = 15;
    localparam int Y_SUM_W      = 23;
    localparam int C_SUM_W      = 24;

    // Register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(176);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(144);
    localparam logic [CFG_W-1:0] MAX_W_SIZE   = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H_SIZE   = CFG_W'(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] MIN_SIZE     = CFG_W'(2);

    // Per-pixel bookkeeping that travels with each word
    typedef struct packed {
        logic [LUMA_OFF_W-1:0]   luma_offset;
        logic [CHROMA_OFF_W-1:0] chroma_offset;
        logic [LINE_IDX_W-1:0]   line_idx;
        logic                    col_odd;
        logic                    row_odd;
        logic                    frame_end;
    } r2y_tag_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        r2y_tag_t           tag;
    } r2y_cmd_t;

    // Even size, floored at two and saturated at the limit
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] raw,
                                                  input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] s;
        s = {raw[CFG_W-1:1], 1'b0};
        if (s < MIN_SIZE)
        begin
            s = MIN_SIZE;
        end
        if (s > maxv)
        begin
            s = {maxv[CFG_W-1:1], 1'b0};
        end
        return s;
    endfunction

    function automatic logic [7:0] clip8(input logic [C_SUM_W-FRAC_BITS-1:0] v);
        return (v > (C_SUM_W-FRAC_BITS)'(255)) ? 8'd255 : v[7:0];
    endfunction

endpackage

// ===== sv/rgb565_to_yuv420_semiplanar.sv =====
// Top level of the RGB565 to YUV 4:2:0 semiplanar (NV12) converter.
//
// Feed RGB565 pixels in raster order, one word per pixel. Every input word
// produces exactly one output word carrying the pixel's clipped Y and its
// byte offset in the luma plane. On each odd-column pixel of an odd row,
// chroma_valid rises and the word also carries the rounded averages of the
// four U and four V values of the 2x2 block, with the byte offset of U in
// the interleaved UV plane after the luma plane (V sits one byte higher).
// frame_end marks the last pixel of a frame; the next pixel starts a new one.
// Frame width and height come from two registers (index 0 and 1, low bit
// ignored, clamped to 2..2048); write them only while the block is drained,
// and note that any write restarts the frame. Throughput is one pixel per
// clock while the output is not stalled; the colour pipeline is four stages
// deep, and each accepted word passes the queue and then those stages. The
// front end feeds a four-word queue, so the input keeps flowing until it
// fills after the output stalls. The even-row chroma pair sums sit in a
// 1024-entry single-port line buffer, one access per pixel pair.
module rgb565_to_yuv420_semiplanar (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic                             cfg_index,
    input  logic [r2y_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [r2y_pkg::PIXEL_W-1:0]      pixel,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       luma,
    output logic [r2y_pkg::LUMA_OFF_W-1:0]   luma_offset,
    output logic                             chroma_valid,
    output logic [7:0]                       u_value,
    output logic [7:0]                       v_value,
    output logic [r2y_pkg::CHROMA_OFF_W-1:0] chroma_offset,
    output logic                             frame_end
);

    logic              push, queue_ready, queue_avail, pop;
    r2y_pkg::r2y_cmd_t push_cmd, head_cmd;

    // Front end: track the raster position and tag each pixel
    r2y_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .pixel       (pixel),
        .queue_ready (queue_ready),
        .push        (push),
        .cmd         (push_cmd)
    );

    // Decouple input acceptance from output back-pressure
    r2y_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .ready     (queue_ready),
        .pop       (pop),
        .avail     (queue_avail),
        .pop_data  (head_cmd)
    );

    // Colour conversion, chroma averaging and the output register
    r2y_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_avail     (queue_avail),
        .cmd           (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .luma          (luma),
        .luma_offset   (luma_offset),
        .chroma_valid  (chroma_valid),
        .u_value       (u_value),
        .v_value       (v_value),
        .chroma_offset (chroma_offset),
        .frame_end     (frame_end)
    );

    assign in_ready = queue_ready;

    // Chroma only on odd columns (odd luma offset); the chroma offset stays even
    a_chroma_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (chroma_offset[0] == 1'b0) && (!chroma_valid || luma_offset[0]))
        else $error("chroma word out of 2x2 alignment");

    // Last pixel of a frame closes a 2x2 block
    a_frame_end_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> chroma_valid)
        else $error("frame end without chroma pair");

    // A size write restarts the raster at the first pixel
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cfg_write) && push) |-> (push_cmd.tag.luma_offset == '0))
        else $error("frame not restarted after size write");

endmodule

// ===== sv/r2y_ram.sv =====
// Generic single-port RAM with registered read.
module r2y_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/r2y_front.sv =====
// Front end: size registers, raster position tracking and offset generation.
module r2y_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [r2y_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    input  logic [r2y_pkg::PIXEL_W-1:0] pixel,
    input  logic                        queue_ready,
    output logic                        push,
    output r2y_pkg::r2y_cmd_t           cmd
);

    logic [r2y_pkg::CFG_W-1:0]        width_reg;
    logic [r2y_pkg::CFG_W-1:0]        height_reg;
    logic [r2y_pkg::COL_W-1:0]        col_reg, col_next;
    logic [r2y_pkg::ROW_W-1:0]        row_reg, row_next;
    logic [r2y_pkg::LUMA_OFF_W-1:0]   luma_off_reg, luma_off_next;
    logic [r2y_pkg::LUMA_OFF_W-1:0]   line_reg, line_next;
    logic [r2y_pkg::CHROMA_OFF_W-1:0] area_reg;
    logic [r2y_pkg::CFG_W-1:0]        w_eff, h_eff;
    logic [2*r2y_pkg::CFG_W-1:0]      area;
    logic                             col_last, row_last;

    assign w_eff = r2y_pkg::eff_size(width_reg, r2y_pkg::MAX_W_SIZE);
    assign h_eff = r2y_pkg::eff_size(height_reg, r2y_pkg::MAX_H_SIZE);
    assign area  = {r2y_pkg::CFG_W'(0), w_eff} * {r2y_pkg::CFG_W'(0), h_eff};

    assign col_last = (r2y_pkg::CFG_W'(col_reg) + r2y_pkg::CFG_W'(1)) >= w_eff;
    assign row_last = (r2y_pkg::CFG_W'(row_reg) + r2y_pkg::CFG_W'(1)) >= h_eff;

    assign push = in_valid && queue_ready;

    always_comb
    begin
        cmd.pixel             = pixel;
        cmd.tag.luma_offset   = luma_off_reg;
        cmd.tag.chroma_offset = area_reg
                              + r2y_pkg::CHROMA_OFF_W'(line_reg)
                              + r2y_pkg::CHROMA_OFF_W'({col_reg[r2y_pkg::COL_W-1:1], 1'b0});
        cmd.tag.line_idx      = col_reg[r2y_pkg::COL_W-1:1];
        cmd.tag.col_odd       = col_reg[0];
        cmd.tag.row_odd       = row_reg[0];
        cmd.tag.frame_end     = col_last && row_last;
    end

    // Advance the raster position by one pixel
    always_comb
    begin
        col_next      = col_reg + r2y_pkg::COL_W'(1);
        row_next      = row_reg;
        luma_off_next = luma_off_reg + r2y_pkg::LUMA_OFF_W'(1);
        line_next     = line_reg;
        if (col_last)
        begin
            col_next = '0;
            if (row_last)
            begin
                row_next      = '0;
                luma_off_next = '0;
                line_next     = '0;
            end
            else
            begin
                row_next = row_reg + r2y_pkg::ROW_W'(1);
                if (row_reg[0])
                begin
                    line_next = line_reg + r2y_pkg::LUMA_OFF_W'(w_eff);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= r2y_pkg::RESET_WIDTH;
            height_reg   <= r2y_pkg::RESET_HEIGHT;
            col_reg      <= '0;
            row_reg      <= '0;
            luma_off_reg <= '0;
            line_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                r2y_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                r2y_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
            // Any size write restarts the frame
            col_reg      <= '0;
            row_reg      <= '0;
            luma_off_reg <= '0;
            line_reg     <= '0;
        end
        else if (push)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            luma_off_reg <= luma_off_next;
            line_reg     <= line_next;
        end
    end

    // Luma plane size, recomputed every cycle; first use is a row later
    always_ff @(posedge clk)
    begin
        area_reg <= area[r2y_pkg::CHROMA_OFF_W-1:0];
    end

endmodule

// ===== sv/r2y_fifo.sv =====
// Short queue of pixel words between the front end and the colour pipeline.
module r2y_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  r2y_pkg::r2y_cmd_t push_data,
    output logic              ready,
    input  logic              pop,
    output logic              avail,
    output r2y_pkg::r2y_cmd_t pop_data
);

    r2y_pkg::r2y_cmd_t              slot_reg [r2y_pkg::FIFO_DEPTH];
    logic [r2y_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [r2y_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    assign ready    = count_reg != r2y_pkg::FIFO_CNT_W'(r2y_pkg::FIFO_DEPTH);
    assign avail    = count_reg != '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + r2y_pkg::FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - r2y_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + r2y_pkg::FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + r2y_pkg::FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/r2y_back.sv =====
// Colour pipeline: matrix, clipping, 2x2 chroma averaging and output register.
module r2y_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_avail,
    input  r2y_pkg::r2y_cmd_t                cmd,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       luma,
    output logic [r2y_pkg::LUMA_OFF_W-1:0]   luma_offset,
    output logic                             chroma_valid,
    output logic [7:0]                       u_value,
    output logic [7:0]                       v_value,
    output logic [r2y_pkg::CHROMA_OFF_W-1:0] chroma_offset,
    output logic                             frame_end
);

    localparam int SHIFTED_W = r2y_pkg::C_SUM_W - r2y_pkg::FRAC_BITS;
    localparam int PSW       = r2y_pkg::PAIR_SUM_W;

    logic                           adv;
    logic [4:0]                     red, blue;
    logic [5:0]                     green;
    logic [31:0]                    y_sum, u_sum, v_sum;

    // Stage 1: matrix sums
    logic                           s1_valid_reg;
    r2y_pkg::r2y_tag_t              s1_tag_reg;
    logic [r2y_pkg::Y_SUM_W-1:0]    s1_y_reg;
    logic [r2y_pkg::C_SUM_W-1:0]    s1_u_reg, s1_v_reg;

    // Stage 2: clipped components
    logic                           s2_valid_reg;
    r2y_pkg::r2y_tag_t              s2_tag_reg;
    logic [7:0]                     s2_y_reg, s2_u_reg, s2_v_reg;
    logic [7:0]                     left_u_reg, left_v_reg;
    logic [PSW-1:0]                 pair_u, pair_v;

    // Stage 3: horizontal pair sums, line buffer access
    logic                           s3_valid_reg;
    r2y_pkg::r2y_tag_t              s3_tag_reg;
    logic [7:0]                     s3_y_reg;
    logic [PSW-1:0]                 s3_u_reg, s3_v_reg;
    logic                           line_we, line_re;
    logic [r2y_pkg::LINE_ENTRY_W-1:0] line_rdata;
    logic [PSW:0]                   quad_u, quad_v;
    logic                           s3_chroma;

    logic                           out_valid_reg;
    logic [7:0]                     luma_reg, u_reg, v_reg;
    logic [r2y_pkg::LUMA_OFF_W-1:0] luma_off_reg;
    logic [r2y_pkg::CHROMA_OFF_W-1:0] chroma_off_reg;
    logic                           chroma_valid_reg, frame_end_reg;

    // Whole pipeline moves together whenever the output register frees up
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && cmd_avail;

    assign red   = cmd.pixel[15:11];
    assign green = cmd.pixel[10:5];
    assign blue  = cmd.pixel[4:0];

    // Biased chroma sums never go negative, so the shift is a floor
    always_comb
    begin
        y_sum = r2y_pkg::COEF_Y_R * 32'(red) + r2y_pkg::COEF_Y_G * 32'(green)
              + r2y_pkg::COEF_Y_B * 32'(blue);
        u_sum = r2y_pkg::COEF_UV_BR * 32'(blue) + r2y_pkg::CHROMA_BIAS
              - r2y_pkg::COEF_U_R * 32'(red) - r2y_pkg::COEF_U_G * 32'(green);
        v_sum = r2y_pkg::COEF_UV_BR * 32'(red) + r2y_pkg::CHROMA_BIAS
              - r2y_pkg::COEF_V_G * 32'(green) - r2y_pkg::COEF_V_B * 32'(blue);
    end

    assign pair_u = PSW'(s2_u_reg) + PSW'(left_u_reg);
    assign pair_v = PSW'(s2_v_reg) + PSW'(left_v_reg);

    // Even rows store the pair sums, odd rows fetch them back
    assign line_we = adv && s2_valid_reg && s2_tag_reg.col_odd && !s2_tag_reg.row_odd;
    assign line_re = adv && s2_valid_reg && s2_tag_reg.col_odd && s2_tag_reg.row_odd;

    r2y_ram #(
        .WIDTH (r2y_pkg::LINE_ENTRY_W),
        .DEPTH (r2y_pkg::LINE_DEPTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (line_we),
        .re    (line_re),
        .addr  (s2_tag_reg.line_idx),
        .wdata ({pair_u, pair_v}),
        .rdata (line_rdata)
    );

    assign s3_chroma = s3_tag_reg.col_odd && s3_tag_reg.row_odd;
    assign quad_u = (PSW+1)'(s3_u_reg) + (PSW+1)'(line_rdata[2*PSW-1:PSW])
                  + (PSW+1)'(2);
    assign quad_v = (PSW+1)'(s3_v_reg) + (PSW+1)'(line_rdata[PSW-1:0])
                  + (PSW+1)'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= cmd_avail;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= cmd.tag;
            s1_y_reg   <= y_sum[r2y_pkg::Y_SUM_W-1:0];
            s1_u_reg   <= u_sum[r2y_pkg::C_SUM_W-1:0];
            s1_v_reg   <= v_sum[r2y_pkg::C_SUM_W-1:0];

            s2_tag_reg <= s1_tag_reg;
            s2_y_reg   <= r2y_pkg::clip8(SHIFTED_W'(s1_y_reg >> r2y_pkg::FRAC_BITS));
            s2_u_reg   <= r2y_pkg::clip8(SHIFTED_W'(s1_u_reg >> r2y_pkg::FRAC_BITS));
            s2_v_reg   <= r2y_pkg::clip8(SHIFTED_W'(s1_v_reg >> r2y_pkg::FRAC_BITS));

            // Hold the left pixel of each pair for its right neighbour
            if (s2_valid_reg && !s2_tag_reg.col_odd)
            begin
                left_u_reg <= s2_u_reg;
                left_v_reg <= s2_v_reg;
            end

            s3_tag_reg <= s2_tag_reg;
            s3_y_reg   <= s2_y_reg;
            s3_u_reg   <= pair_u;
            s3_v_reg   <= pair_v;

            luma_reg         <= s3_y_reg;
            luma_off_reg     <= s3_tag_reg.luma_offset;
            frame_end_reg    <= s3_tag_reg.frame_end;
            chroma_valid_reg <= s3_chroma;
            u_reg            <= s3_chroma ? quad_u[PSW:2] : 8'd0;
            v_reg            <= s3_chroma ? quad_v[PSW:2] : 8'd0;
            chroma_off_reg   <= s3_chroma ? s3_tag_reg.chroma_offset : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign luma          = luma_reg;
    assign luma_offset   = luma_off_reg;
    assign chroma_valid  = chroma_valid_reg;
    assign u_value       = u_reg;
    assign v_value       = v_reg;
    assign chroma_offset = chroma_off_reg;
    assign frame_end     = frame_end_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the RGB565 to NV12 converter: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module testbench;

    // One output word as the block presents it
    typedef struct packed {
        logic [7:0]                       luma;
        logic [r2y_pkg::LUMA_OFF_W-1:0]   luma_offset;
        logic                             chroma_valid;
        logic [7:0]                       u_value;
        logic [7:0]                       v_value;
        logic [r2y_pkg::CHROMA_OFF_W-1:0] chroma_offset;
        logic                             frame_end;
    } yuv_word_t;

    // Scoreboard: a colour-conversion predictor with its own copy of the frame
    // counters, the left-pixel chroma and the even-row pair sums, plus the
    // queue of words still owed by the block.
    class nv12_scoreboard;
        logic [r2y_pkg::CFG_W-1:0]        width_reg;
        logic [r2y_pkg::CFG_W-1:0]        height_reg;
        int unsigned                      col;
        int unsigned                      row;
        logic [15:0]                      left_chroma;
        logic [r2y_pkg::LINE_ENTRY_W-1:0] pair_sums [r2y_pkg::LINE_DEPTH];
        yuv_word_t                        owed_words [$];
        int unsigned                      mismatches;
        int unsigned                      words_seen;
        int unsigned                      chroma_words;
        int unsigned                      frame_ends;

        function new();
            width_reg    = 12'd176;
            height_reg   = 12'd144;
            col          = 0;
            row          = 0;
            left_chroma  = '0;
            mismatches   = 0;
            words_seen   = 0;
            chroma_words = 0;
            frame_ends   = 0;
            foreach (pair_sums[i]) pair_sums[i] = '0;
        endfunction

        function int unsigned backlog();
            return owed_words.size();
        endfunction

        // Even size, at least two, capped at the limit
        function int unsigned frame_dim(logic [r2y_pkg::CFG_W-1:0] raw, int unsigned limit);
            int unsigned s;
            s = raw & 12'hFFE;
            if (s < 2) s = 2;
            if (s > limit) s = limit & 32'hFFFF_FFFE;
            return s;
        endfunction

        function int unsigned saturate(int unsigned x);
            return (x > 255) ? 255 : x;
        endfunction

        // Any register write restarts the frame
        function void write_reg(logic idx, logic [r2y_pkg::CFG_W-1:0] value);
            if (idx == r2y_pkg::REG_FRAME_WIDTH)
                width_reg = value;
            else
                height_reg = value;
            col         = 0;
            row         = 0;
            left_chroma = '0;
        endfunction

        function void note_pixel(logic [r2y_pkg::PIXEL_W-1:0] px);
            int unsigned w, h, r, g, b, y, u, v, us, vs, idx;
            yuv_word_t   want;
            w    = frame_dim(width_reg, r2y_pkg::MAX_WIDTH);
            h    = frame_dim(height_reg, r2y_pkg::MAX_HEIGHT);
            r    = px[15:11];
            g    = px[10:5];
            b    = px[4:0];
            want = '0;
            // Chroma carries a bias of 128 << 15 so every sum stays non-negative
            y = saturate((80593 * r + 77855 * g + 30728 * b) >> 15);
            u = saturate((134771 * b + 4194304 - 45483 * r - 43936 * g) >> 15);
            v = saturate((134771 * r + 4194304 - 55532 * g - 21917 * b) >> 15);
            want.luma        = y[7:0];
            want.luma_offset = r2y_pkg::LUMA_OFF_W'(row * w + col);
            if (col[0] == 1'b0)
            begin
                left_chroma = {u[7:0], v[7:0]};
            end
            else
            begin
                us  = u + left_chroma[15:8];
                vs  = v + left_chroma[7:0];
                idx = (col >> 1) % r2y_pkg::LINE_DEPTH;
                if (row[0] == 1'b0)
                begin
                    pair_sums[idx] = {us[8:0], vs[8:0]};
                end
                else
                begin
                    us = us + pair_sums[idx][17:9];
                    vs = vs + pair_sums[idx][8:0];
                    want.chroma_valid  = 1'b1;
                    want.u_value       = 8'((us + 2) >> 2);
                    want.v_value       = 8'((vs + 2) >> 2);
                    want.chroma_offset =
                        r2y_pkg::CHROMA_OFF_W'(w * h + (row >> 1) * w + col - 1);
                end
            end
            want.frame_end = (row + 1 >= h) && (col + 1 >= w);
            if (col + 1 >= w)
            begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end
            else
            begin
                col = col + 1;
            end
            owed_words.push_back(want);
        endfunction

        function void check_word(yuv_word_t got);
            yuv_word_t want;
            if (owed_words.size() == 0)
            begin
                $error("output word with nothing expected: luma_offset %0d", got.luma_offset);
                mismatches++;
                return;
            end
            want = owed_words.pop_front();
            words_seen++;
            if (want.chroma_valid) chroma_words++;
            if (want.frame_end) frame_ends++;
            if (got.luma !== want.luma)
            begin
                $error("luma: expected %0d, got %0d", want.luma, got.luma);
                mismatches++;
            end
            if (got.luma_offset !== want.luma_offset)
            begin
                $error("luma_offset: expected %0d, got %0d", want.luma_offset, got.luma_offset);
                mismatches++;
            end
            if (got.chroma_valid !== want.chroma_valid)
            begin
                $error("chroma_valid: expected %0d, got %0d", want.chroma_valid, got.chroma_valid);
                mismatches++;
            end
            if (got.u_value !== want.u_value)
            begin
                $error("u_value: expected %0d, got %0d", want.u_value, got.u_value);
                mismatches++;
            end
            if (got.v_value !== want.v_value)
            begin
                $error("v_value: expected %0d, got %0d", want.v_value, got.v_value);
                mismatches++;
            end
            if (got.chroma_offset !== want.chroma_offset)
            begin
                $error("chroma_offset: expected %0d, got %0d",
                       want.chroma_offset, got.chroma_offset);
                mismatches++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
                mismatches++;
            end
        endfunction
    endclass

    // Every input starts at a known value
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_write = 1'b0;
    logic                             cfg_index = r2y_pkg::REG_FRAME_WIDTH;
    logic [r2y_pkg::CFG_W-1:0]        cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic [r2y_pkg::PIXEL_W-1:0]      pixel     = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [7:0]                       luma;
    logic [r2y_pkg::LUMA_OFF_W-1:0]   luma_offset;
    logic                             chroma_valid;
    logic [7:0]                       u_value;
    logic [7:0]                       v_value;
    logic [r2y_pkg::CHROMA_OFF_W-1:0] chroma_offset;
    logic                             frame_end;

    // When set, neither side idles: gives long unbroken stretches
    bit                      calm = 1'b0;
    int unsigned             settings_run = 1;

    nv12_scoreboard tracker = new();

    rgb565_to_yuv420_semiplanar dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .luma          (luma),
        .luma_offset   (luma_offset),
        .chroma_valid  (chroma_valid),
        .u_value       (u_value),
        .v_value       (v_value),
        .chroma_offset (chroma_offset),
        .frame_end     (frame_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Corner pixels: black, white, the primaries and secondaries at full
    // strength (which drive U and V to both ends of their range), then every single bit.
    function automatic logic [r2y_pkg::PIXEL_W-1:0] corner_pixel(int k);
        case (k)
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'hF800;
            3:       return 16'h07E0;
            4:       return 16'h001F;
            5:       return 16'hFFE0;
            6:       return 16'hF81F;
            7:       return 16'h07FF;
            default: return 16'h0001 << (k - 8);
        endcase
    endfunction

    // Mostly arbitrary colours, with a share of corners mixed in
    function automatic logic [r2y_pkg::PIXEL_W-1:0] pick_pixel();
        if ($urandom_range(3) == 0)
            return corner_pixel($urandom_range(23));
        return r2y_pkg::PIXEL_W'($urandom);
    endfunction

    // Hold off until every owed word has come back
    task automatic wait_drained();
        while (tracker.backlog() != 0) @(posedge clk);
    endtask

    // Present one word and hold it until the block takes it
    task automatic send_pixel(input logic [r2y_pkg::PIXEL_W-1:0] px);
        if (!calm)
        begin
            while ($urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        pixel    <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_pixel(px);
    endtask

    // Write both size registers back to back; each write restarts the frame
    task automatic set_frame(input logic [r2y_pkg::CFG_W-1:0] w,
                             input logic [r2y_pkg::CFG_W-1:0] h);
        cfg_write <= 1'b1;
        cfg_index <= r2y_pkg::REG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        tracker.write_reg(r2y_pkg::REG_FRAME_WIDTH, w);
        cfg_index <= r2y_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        tracker.write_reg(r2y_pkg::REG_FRAME_HEIGHT, h);
        cfg_write <= 1'b0;
        settings_run++;
    endtask

    // Random words; the first calm_count run without idling, and at pause_at
    // the sender drops valid and waits for the block to drain completely
    task automatic stream_pixels(input int count, input int calm_count, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            calm = (i < calm_count);
            if (pause_at > 0 && i == pause_at)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            send_pixel(pick_pixel());
        end
        in_valid <= 1'b0;
        calm = 1'b0;
    endtask

    task automatic run_phase(input logic [r2y_pkg::CFG_W-1:0] w,
                             input logic [r2y_pkg::CFG_W-1:0] h,
                             input int count, input int calm_count, input int pause_at);
        wait_drained();
        set_frame(w, h);
        stream_pixels(count, calm_count, pause_at);
    endtask

    // Output side: stall at random, check every word taken
    initial
    begin
        yuv_word_t got;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = '{luma, luma_offset, chroma_valid, u_value, v_value,
                        chroma_offset, frame_end};
                tracker.check_word(got);
            end
            out_ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // Stimulus
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size 176x144: corner pixels, then enough random words to
        // reach the first odd row and on into the second even row
        for (int k = 0; k < 24; k++) send_pixel(corner_pixel(k));
        stream_pixels(340, 0, 0);

        // Sizes below two are floored: 2x2 frames, chroma on every fourth word
        run_phase(12'd0, 12'd1, 40, 0, 0);
        // Odd width rounds down to two; oversized height caps at the limit
        run_phase(12'd3, 12'd4095, 64, 0, 0);
        run_phase(12'd6, 12'd4, 200, 0, 0);
        // One full 64x4 frame and more, the first stretch with no idling
        run_phase(12'd64, 12'd4, 300, 250, 0);
        // Drain completely mid-frame before carrying on
        run_phase(12'd10, 12'd6, 300, 0, 150);
        run_phase(12'd2050, 12'd2049, 20, 0, 0);
        run_phase(12'd2048, 12'd2048, 24, 0, 0);
        run_phase(12'd16, 12'd8, 40, 0, 20);

        // Let the tail out and catch any stray words
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Checked %0d words over %0d frame sizes (2x2 up to 2048 wide).",
                 tracker.words_seen, settings_run);
        $display("Saw %0d chroma pairs and %0d frame ends.",
                 tracker.chroma_words, tracker.frame_ends);
        if (tracker.mismatches == 0 && tracker.backlog() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/r2y_pkg.sv
sv/r2y_ram.sv
sv/r2y_front.sv
sv/r2y_fifo.sv
sv/r2y_back.sv
sv/rgb565_to_yuv420_semiplanar.sv
tb/testbench.sv
